// File: hdl/tmps_pkg.sv
// shared constants and types for the triangle maximum path sum block
`default_nettype none

package tmps_pkg;

  // defaults for the top-level parameters
  localparam int MAX_ROWS_DEF  = 1024;
  localparam int SUM_WIDTH_DEF = 48;

  // fixed field widths
  localparam int ENTRY_W   = 32;
  localparam int ROW_CNT_W = 11;

  // row count after reset
  localparam logic [ROW_CNT_W-1:0] ROW_CNT_RST = ROW_CNT_W'(1);

  // per-entry flags carried from the read stage into the update stage
  typedef struct packed {
    logic row_zero;  // top row: sum is the entry itself
    logic col_zero;  // left edge: only the parent straight above
    logic edge_r;    // right edge: only the left parent
    logic last;      // final entry of the triangle
  } tmps_flags_t;

endpackage

`default_nettype wire

// File: hdl/triangle_max_path_sum.sv
// triangle maximum path sum: row store, update stage and result buffer
//
// Usage: entries of a number triangle stream in on the in_ channel, row by
// row and left to right, row r holding r+1 entries. One entry is taken per
// cycle while in_tready is high. The cfg_ port sets the number of rows; zero counts
// as one row and values above MAX_ROWS are clamped. Write it only while the block is idle.
// After the final entry of the last row the maximum top-to-bottom path sum
// leaves on the out_ channel via the update stage and result buffer, and the
// row and column counters start over for the next triangle.
// Each entry costs one read of the row store at the accept edge and one
// write back in the following cycle; the sum just written is forwarded when
// the next entry reads the same column, so while in_tready is high the rate is one entry per cycle.
// Results wait in a three-entry output buffer. While the receiver stalls the
// input keeps flowing until the buffer could overflow; then in_tready drops.
// A synchronous active-low reset clears counters, the buffer and the running
// maximum and sets the row count to one. The row store is not cleared: each
// column is written in a row before the next row reads it.
`default_nettype none

module triangle_max_path_sum #(
  parameter int MAX_ROWS  = tmps_pkg::MAX_ROWS_DEF,
  parameter int SUM_WIDTH = tmps_pkg::SUM_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_wr_en,
  input  wire logic [tmps_pkg::ROW_CNT_W-1:0]      cfg_wr_data,   // row_count
  // entry requests
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [tmps_pkg::ENTRY_W-1:0]        in_tdata,      // [31:0] entry_value
  // result requests
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((SUM_WIDTH+7)/8)*8-1:0]           out_tdata      // best_sum, zero padded
);

  import tmps_pkg::*;

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CMP_W = (IDX_W + 1 > ROW_CNT_W) ? IDX_W + 1 : ROW_CNT_W;
  localparam int OUT_W = ((SUM_WIDTH + 7) / 8) * 8;

  // signed maximum at sum width
  function automatic logic [SUM_WIDTH-1:0] larger(input logic [SUM_WIDTH-1:0] a,
                                                  input logic [SUM_WIDTH-1:0] b);
    larger = ($signed(a) > $signed(b)) ? a : b;
  endfunction

  // configuration register
  logic [ROW_CNT_W-1:0] row_count_r;
  logic [CMP_W-1:0]     row_cnt_ext;
  logic [CMP_W-1:0]     row_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_CNT_RST;
    end else if (cfg_wr_en) begin
      row_count_r <= cfg_wr_data;
    end
  end

  // effective number of rows
  always_comb begin
    row_cnt_ext = CMP_W'(row_count_r);
    if (row_cnt_ext == '0) begin
      row_lim = CMP_W'(1);
    end else if (row_cnt_ext > CMP_W'(MAX_ROWS)) begin
      row_lim = CMP_W'(MAX_ROWS);
    end else begin
      row_lim = row_cnt_ext;
    end
  end

  // handshake and position counters
  logic              in_acc;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  tmps_flags_t       acc_flags;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              s1_valid_r;
  tmps_flags_t       s1_flags_r;

  assign in_tready = ({1'b0, cnt_r} + {2'b00, s1_valid_r & s1_flags_r.last}) <= 3'd2;
  assign in_acc    = in_tvalid & in_tready;

  always_comb begin
    acc_flags.row_zero = (row_r == '0);
    acc_flags.col_zero = (col_r == '0);
    acc_flags.edge_r   = (col_r >= row_r);
    acc_flags.last     = acc_flags.edge_r &&
                         ((CMP_W'(row_r) + CMP_W'(1)) >= row_lim);
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_acc) begin
      if (acc_flags.last) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (acc_flags.edge_r) begin
        row_nxt = row_r + IDX_W'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // row store: read at accept, written back in the next cycle
  logic [SUM_WIDTH-1:0] path_mem [MAX_ROWS];
  logic [SUM_WIDTH-1:0] rd_data_r;
  logic [IDX_W-1:0]     s1_col_r;
  logic [ENTRY_W-1:0]   s1_entry_r;
  logic                 fwd_r;
  logic [SUM_WIDTH-1:0] fwd_data_r;
  logic [SUM_WIDTH-1:0] sum_s1;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      path_mem[s1_col_r] <= sum_s1;
    end
    if (in_acc) begin
      rd_data_r <= path_mem[col_r];
    end
  end

  // stage 1 capture, with forwarding of a write to the column being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (in_acc) begin
        fwd_r <= s1_valid_r && (s1_col_r == col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flags_r <= acc_flags;
      s1_col_r   <= col_r;
      s1_entry_r <= in_tdata;
      fwd_data_r <= sum_s1;
    end
  end

  // path sum update
  logic [SUM_WIDTH-1:0] old_here;
  logic [SUM_WIDTH-1:0] entry_ext;
  logic [SUM_WIDTH-1:0] left_r;
  logic [SUM_WIDTH-1:0] best_r, best_nxt;

  always_comb begin
    old_here  = fwd_r ? fwd_data_r : rd_data_r;
    entry_ext = {{(SUM_WIDTH-ENTRY_W){s1_entry_r[ENTRY_W-1]}}, s1_entry_r};
    if (s1_flags_r.row_zero) begin
      sum_s1 = entry_ext;
    end else if (s1_flags_r.col_zero) begin
      sum_s1 = entry_ext + old_here;
    end else if (s1_flags_r.edge_r) begin
      sum_s1 = entry_ext + left_r;
    end else begin
      sum_s1 = entry_ext + larger(left_r, old_here);
    end
    best_nxt = s1_flags_r.col_zero ? sum_s1 : larger(best_r, sum_s1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      best_r <= '0;
    end else if (s1_valid_r) begin
      left_r <= old_here;
      best_r <= best_nxt;
    end
  end

  // three-entry result buffer
  logic                 push, pop;
  logic [1:0]           wr_slot;
  logic [SUM_WIDTH-1:0] q0_r, q1_r, q2_r;

  assign push    = s1_valid_r & s1_flags_r.last;
  assign pop     = (cnt_r != 2'd0) & out_tready;
  assign wr_slot = cnt_r - {1'b0, pop};
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // shift toward the head on pop, new result lands behind the survivors
  always_ff @(posedge clk) begin
    if (push && (wr_slot == 2'd0)) begin
      q0_r <= best_nxt;
    end else if (pop) begin
      q0_r <= q1_r;
    end
    if (push && (wr_slot == 2'd1)) begin
      q1_r <= best_nxt;
    end else if (pop) begin
      q1_r <= q2_r;
    end
    if (push && (wr_slot == 2'd2)) begin
      q2_r <= best_nxt;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = OUT_W'(q0_r);

`ifndef SYNTHESIS
  // a result never arrives at a full buffer that is not draining
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !((cnt_r == 2'd3) && !pop))
    else $error("result buffer overflow");

  // a full buffer always holds off new entries
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd3) |-> !in_tready)
    else $error("entry taken with result buffer full");

  // the final entry always leaves the counters at the triangle's start
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (row_r == '0) && (col_r == '0))
    else $error("counters not cleared after final entry");

  // the column never runs past the row
  assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= row_r)
    else $error("column past end of row");
`endif

endmodule

`default_nettype wire
